// ===== src/ymb_pkg.sv =====
// Package for the YModem batch sender: phase and state types, control codes,
// and per-item helper functions (CRC-16/XMODEM byte step, packet bookkeeping).
// No dependencies.
`default_nettype none
package ymb_pkg;

	localparam int DATA_BLOCK   = 1024;
	localparam int HEADER_BLOCK = 128;
	localparam int PBC_W        = $clog2(DATA_BLOCK + 1);

	localparam logic [PBC_W-1:0] DATA_LEN   = PBC_W'(DATA_BLOCK);
	localparam logic [PBC_W-1:0] HEADER_LEN = PBC_W'(HEADER_BLOCK);

	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_EOT   = 8'h04;
	localparam logic [7:0] CH_ACK   = 8'h06;
	localparam logic [7:0] CH_NAK   = 8'h15;
	localparam logic [7:0] CH_CAN   = 8'h18;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] PAD_DATA = 8'h1A;
	localparam logic [7:0] PAD_HDR  = 8'h00;
	localparam logic [7:0] DATA_LEAD = (DATA_BLOCK > 128) ? CH_STX : CH_SOH;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [15:0] START_TICKS_RST  = 16'd20000;
	localparam logic [15:0] HEADER_TICKS_RST = 16'd2000;
	localparam logic [15:0] PACKET_TICKS_RST = 16'd1000;
	localparam logic [15:0] EOT_TICKS_RST    = 16'd3000;

	localparam logic [2:0] MODE_REPLY   = 3'd0;
	localparam logic [2:0] MODE_CONTENT = 3'd1;
	localparam logic [2:0] MODE_PULL    = 3'd2;
	localparam logic [2:0] MODE_TICK    = 3'd3;
	localparam logic [2:0] MODE_START   = 3'd4;

	localparam logic [2:0] CFG_FILE_LENGTH  = 3'd0;
	localparam logic [2:0] CFG_START_TICKS  = 3'd1;
	localparam logic [2:0] CFG_HEADER_TICKS = 3'd2;
	localparam logic [2:0] CFG_PACKET_TICKS = 3'd3;
	localparam logic [2:0] CFG_EOT_TICKS    = 3'd4;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SENDING = 3'd1;
	localparam logic [2:0] ST_WAITING = 3'd2;
	localparam logic [2:0] ST_DONE    = 3'd3;
	localparam logic [2:0] ST_ABORTED = 3'd4;

	localparam logic [1:0] FP_LEAD   = 2'd0;
	localparam logic [1:0] FP_BODY   = 2'd1;
	localparam logic [1:0] FP_CRC_HI = 2'd2;
	localparam logic [1:0] FP_CRC_LO = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_WAIT_START  = 4'd1,
		PH_SEND_HEADER = 4'd2,
		PH_WAIT_HEADER = 4'd3,
		PH_SEND_DATA   = 4'd4,
		PH_WAIT_DATA   = 4'd5,
		PH_SEND_EOT    = 4'd6,
		PH_WAIT_EOT    = 4'd7,
		PH_SEND_NULL   = 4'd8,
		PH_WAIT_NULL   = 4'd9,
		PH_DONE        = 4'd10,
		PH_ABORTED     = 4'd11
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic [7:0]         seq;
		logic [15:0]        crc;
		logic [PBC_W-1:0]   pbc;
		logic [23:0]        left;
		logic [15:0]        wcnt;
		logic               ack;
		logic [1:0]         fpos;
		logic               hdone;
	} sender_state_t;

	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic is_wait(phase_t ph);
		return ph == PH_WAIT_START || ph == PH_WAIT_HEADER || ph == PH_WAIT_DATA ||
			ph == PH_WAIT_EOT || ph == PH_WAIT_NULL;
	endfunction

	function automatic logic wants_content(sender_state_t s);
		logic w;
		w = 1'b0;
		if (s.fpos == FP_BODY) begin
			if (s.phase == PH_SEND_HEADER)
				w = !s.hdone && (s.pbc < HEADER_LEN);
			else if (s.phase == PH_SEND_DATA)
				w = (s.left != 24'd0) && (s.pbc < DATA_LEN);
		end
		return w;
	endfunction

	function automatic sender_state_t begin_packet(sender_state_t s, phase_t ph,
			logic [7:0] sq);
		sender_state_t r;
		r       = s;
		r.phase = ph;
		r.seq   = sq;
		r.crc   = '0;
		r.pbc   = '0;
		r.fpos  = FP_LEAD;
		r.hdone = 1'b0;
		r.ack   = 1'b0;
		return r;
	endfunction

	function automatic sender_state_t enter_wait(sender_state_t s, phase_t ph,
			logic [15:0] ticks);
		sender_state_t r;
		r       = s;
		r.phase = ph;
		r.wcnt  = ticks;
		r.ack   = 1'b0;
		return r;
	endfunction

	function automatic sender_state_t abort_transfer(sender_state_t s);
		sender_state_t r;
		r       = s;
		r.phase = PH_ABORTED;
		r.wcnt  = '0;
		return r;
	endfunction

	function automatic sender_state_t next_data_or_eot(sender_state_t s, logic [7:0] sq);
		sender_state_t r;
		r = s;
		if (s.left == 24'd0) begin
			r.phase = PH_SEND_EOT;
			r.ack   = 1'b0;
		end else begin
			r = begin_packet(s, PH_SEND_DATA, sq);
		end
		return r;
	endfunction

	function automatic sender_state_t body_byte(sender_state_t s, logic [7:0] b);
		sender_state_t r;
		r     = s;
		r.crc = crc_feed(s.crc, b);
		r.pbc = s.pbc + PBC_W'(1);
		if (r.pbc >= ((s.phase == PH_SEND_DATA) ? DATA_LEN : HEADER_LEN))
			r.fpos = FP_CRC_HI;
		return r;
	endfunction

	function automatic logic [2:0] status_of(phase_t ph);
		logic [2:0] st;
		if (ph == PH_IDLE)
			st = ST_IDLE;
		else if (ph == PH_DONE)
			st = ST_DONE;
		else if (ph == PH_ABORTED)
			st = ST_ABORTED;
		else if (is_wait(ph))
			st = ST_WAITING;
		else
			st = ST_SENDING;
		return st;
	endfunction

endpackage
`default_nettype wire

// ===== src/ymb_req_if.sv =====
// Request channel of the YModem batch sender: one item per transfer.
// Depends on nothing.
`default_nettype none
interface ymb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] byte_in;
	logic       content_end;

	modport source (output valid, mode, byte_in, content_end, input ready);
	modport sink (input valid, mode, byte_in, content_end, output ready);
endinterface
`default_nettype wire

// ===== src/ymb_rsp_if.sv =====
// Result channel of the YModem batch sender: one result per request item.
// Depends on nothing.
`default_nettype none
interface ymb_rsp_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       packet_last;
	logic       need_content;
	logic       refused;
	logic [2:0] status;

	modport source (output valid, tx_valid, tx_byte, packet_last, need_content, refused,
		status, input ready);
	modport sink (input valid, tx_valid, tx_byte, packet_last, need_content, refused,
		status, output ready);
endinterface
`default_nettype wire

// ===== src/ymb_cfg_if.sv =====
// Configuration write channel of the YModem batch sender: register index and data.
// Depends on nothing.
`default_nettype none
interface ymb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/ymodem_batch_sender.sv =====
// YModem batch sender (CRC-16/XMODEM, one file per batch), top level.
// Depends on ymb_pkg and the interfaces ymb_req_if, ymb_rsp_if, ymb_cfg_if.
//
// Channels: req carries items (receiver byte, content byte, transmit pull, tick,
// start); rsp returns exactly one result per item (transmit byte, packet end,
// content request, refusal, status); cfg writes file length and wait limits,
// always ready; write it only while no item is in flight.
// An item's result is registered and is on rsp in the cycle after its transfer.
// Throughput: one item per cycle while rsp is taken. All state update, including
// the eight-step CRC byte update, sits between the request transfer and the result
// register. The result register frees in the cycle rsp is taken, so req stays ready
// while a waiting result is taken in the same cycle.
// When the receiver of rsp stalls, req drops ready after one held result and
// no item is lost.
// Reset: phase idle, counters and CRC zero, wait limits at their defaults
// (20000, 2000, 1000, 3000 ticks), file length zero, no result pending.
// A start item restarts the transfer from any phase; a timeout or a wrong
// reply moves it to aborted, and the next start begins again.
`default_nettype none
module ymodem_batch_sender (
	input wire logic  clk,
	input wire logic  arst_n,
	ymb_req_if.sink   req,
	ymb_rsp_if.source rsp,
	ymb_cfg_if.sink   cfg
);
	import ymb_pkg::*;

	sender_state_t st_q, nx;
	logic [23:0]   file_length_q;
	logic [15:0]   start_ticks_q, header_ticks_q, packet_ticks_q, eot_ticks_q;
	logic          rsp_valid_q;
	logic          req_fire;
	logic          tx_v, last, refused;
	logic [7:0]    tx_b;
	logic          tx_valid_q, packet_last_q, need_content_q, refused_q;
	logic [7:0]    tx_byte_q;
	logic [2:0]    status_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q  <= '0;
			start_ticks_q  <= START_TICKS_RST;
			header_ticks_q <= HEADER_TICKS_RST;
			packet_ticks_q <= PACKET_TICKS_RST;
			eot_ticks_q    <= EOT_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FILE_LENGTH:  file_length_q  <= cfg.data;
				CFG_START_TICKS:  start_ticks_q  <= cfg.data[15:0];
				CFG_HEADER_TICKS: header_ticks_q <= cfg.data[15:0];
				CFG_PACKET_TICKS: packet_ticks_q <= cfg.data[15:0];
				CFG_EOT_TICKS:    eot_ticks_q    <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else begin
			st_q <= nx;
		end
	end

	always_comb begin
		nx      = st_q;
		tx_v    = 1'b0;
		tx_b    = 8'h00;
		last    = 1'b0;
		refused = 1'b0;
		if (req_fire) begin
			case (req.mode)
				MODE_START: begin
					nx      = begin_packet(st_q, PH_IDLE, 8'h00);
					nx.left = file_length_q;
					nx      = enter_wait(nx, PH_WAIT_START, start_ticks_q);
				end
				MODE_TICK: begin
					if (is_wait(st_q.phase)) begin
						if (st_q.wcnt <= 16'd1)
							nx = abort_transfer(st_q);
						else
							nx.wcnt = st_q.wcnt - 16'd1;
					end
				end
				MODE_REPLY: begin
					unique case (st_q.phase)
						PH_WAIT_START: begin
							if (req.byte_in == CH_C)
								nx = begin_packet(st_q, PH_SEND_HEADER, 8'h00);
						end
						PH_WAIT_HEADER: begin
							if (st_q.ack) begin
								if (req.byte_in == CH_C)
									nx = next_data_or_eot(st_q, 8'h01);
								else
									nx = abort_transfer(st_q);
							end else if (req.byte_in == CH_C) begin
								nx = next_data_or_eot(st_q, 8'h01);
							end else if (req.byte_in == CH_ACK) begin
								nx.ack = 1'b1;
							end else if (req.byte_in == CH_NAK || req.byte_in == CH_CAN) begin
								nx = abort_transfer(st_q);
							end
						end
						PH_WAIT_DATA: begin
							if (req.byte_in == CH_ACK)
								nx = next_data_or_eot(st_q, st_q.seq + 8'h01);
							else if (req.byte_in == CH_NAK || req.byte_in == CH_CAN ||
									req.byte_in == CH_C)
								nx = abort_transfer(st_q);
						end
						PH_WAIT_EOT: begin
							if (st_q.ack) begin
								if (req.byte_in == CH_C)
									nx = begin_packet(st_q, PH_SEND_NULL, 8'h00);
								else
									nx = abort_transfer(st_q);
							end else if (req.byte_in == CH_C) begin
								nx = begin_packet(st_q, PH_SEND_NULL, 8'h00);
							end else if (req.byte_in == CH_ACK) begin
								nx.ack = 1'b1;
							end else if (req.byte_in == CH_NAK) begin
								nx.phase = PH_SEND_EOT;
								nx.ack   = 1'b0;
							end else if (req.byte_in == CH_CAN) begin
								nx = abort_transfer(st_q);
							end
						end
						PH_WAIT_NULL: begin
							if (req.byte_in == CH_ACK) begin
								nx.phase = PH_DONE;
								nx.wcnt  = '0;
							end else if (req.byte_in == CH_NAK || req.byte_in == CH_CAN) begin
								nx = abort_transfer(st_q);
							end
						end
						default: ;
					endcase
				end
				MODE_CONTENT: begin
					if (wants_content(st_q)) begin
						tx_v = 1'b1;
						tx_b = req.byte_in;
						if (st_q.phase == PH_SEND_HEADER) begin
							nx = body_byte(st_q, req.byte_in);
							if (req.content_end || nx.pbc >= HEADER_LEN)
								nx.hdone = 1'b1;
						end else begin
							nx      = body_byte(st_q, req.byte_in);
							nx.left = st_q.left - 24'd1;
						end
					end else begin
						refused = 1'b1;
					end
				end
				MODE_PULL: begin
					if (st_q.phase == PH_SEND_EOT) begin
						tx_v = 1'b1;
						tx_b = CH_EOT;
						last = 1'b1;
						nx   = enter_wait(st_q, PH_WAIT_EOT, eot_ticks_q);
					end else if ((st_q.phase == PH_SEND_HEADER || st_q.phase == PH_SEND_DATA ||
							st_q.phase == PH_SEND_NULL) && !wants_content(st_q)) begin
						tx_v = 1'b1;
						case (st_q.fpos)
							FP_LEAD: begin
								if (st_q.pbc == PBC_W'(0))
									tx_b = (st_q.phase == PH_SEND_DATA) ? DATA_LEAD : CH_SOH;
								else if (st_q.pbc == PBC_W'(1))
									tx_b = st_q.seq;
								else
									tx_b = ~st_q.seq;
								nx.pbc = st_q.pbc + PBC_W'(1);
								if (nx.pbc >= PBC_W'(3)) begin
									nx.fpos = FP_BODY;
									nx.pbc  = '0;
								end
							end
							FP_BODY: begin
								tx_b = (st_q.phase == PH_SEND_DATA) ? PAD_DATA : PAD_HDR;
								nx   = body_byte(st_q, tx_b);
							end
							FP_CRC_HI: begin
								tx_b    = st_q.crc[15:8];
								nx.fpos = FP_CRC_LO;
							end
							default: begin
								tx_b = st_q.crc[7:0];
								last = 1'b1;
								if (st_q.phase == PH_SEND_HEADER)
									nx = enter_wait(st_q, PH_WAIT_HEADER, header_ticks_q);
								else if (st_q.phase == PH_SEND_DATA)
									nx = enter_wait(st_q, PH_WAIT_DATA, packet_ticks_q);
								else
									nx = enter_wait(st_q, PH_WAIT_NULL, packet_ticks_q);
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			tx_valid_q     <= tx_v;
			tx_byte_q      <= tx_b;
			packet_last_q  <= last;
			need_content_q <= wants_content(nx);
			refused_q      <= refused;
			status_q       <= status_of(nx.phase);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.tx_valid     = tx_valid_q;
	assign rsp.tx_byte      = tx_byte_q;
	assign rsp.packet_last  = packet_last_q;
	assign rsp.need_content = need_content_q;
	assign rsp.refused      = refused_q;
	assign rsp.status       = status_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> rsp.valid)
		else $error("no result after request transfer");

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.tx_valid |-> rsp.tx_byte == 8'h00 && !rsp.packet_last)
		else $error("byte or packet end flagged without transmit");

	a_start_waits: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.mode == MODE_START |=> st_q.phase == PH_WAIT_START)
		else $error("start did not enter the start wait");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pbc <= DATA_LEN)
		else $error("packet byte count past block size");

endmodule
`default_nettype wire
